@@ design/ofsga_pkg.sv @@
`default_nettype none
package ofsga_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_DELTA_LIMIT   = 3'd0,
		CFG_QUALITY_FLOOR = 3'd1,
		CFG_GAP_LIMIT     = 3'd2,
		CFG_MIN_WINDOW    = 3'd3,
		CFG_GAIN_X        = 3'd4,
		CFG_GAIN_Y        = 3'd5
	} cfg_idx_t;

	// Result status codes.
	typedef enum logic [3:0] {
		ST_ACCEPTED  = 4'd0,
		ST_FIRST     = 4'd1,
		ST_GAP       = 4'd2,
		ST_READFAIL  = 4'd3,
		ST_DELTA     = 4'd4,
		ST_QUALITY   = 4'd5,
		ST_MOTION    = 4'd6,
		ST_PUBLISHED = 4'd7,
		ST_NOT_READY = 4'd8
	} status_t;

	// What the back end has to do with a queued request.
	typedef enum logic [1:0] {
		KIND_REJECT  = 2'd0,
		KIND_SAMPLE  = 2'd1,
		KIND_PUBLISH = 2'd2
	} kind_t;

	localparam logic [7:0]  MotionValid = 8'hB0;
	localparam logic [19:0] UsecPerSec  = 20'd1000000;
	localparam int QueueDepth = 2;

	// Serial divider geometry: numerator up to 2^83, divisor up to 2^40.
	localparam int NumW     = 84;
	localparam int DivW     = 41;
	localparam int CntW     = 7;
	localparam logic [CntW-1:0] DivLast = CntW'(NumW - 1);

	typedef struct packed {
		logic [14:0]        delta_limit;
		logic [7:0]         quality_floor;
		logic [31:0]        gap_limit_us;
		logic [31:0]        min_window_us;
		logic signed [31:0] gain_x;
		logic signed [31:0] gain_y;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		status_t            status;
		logic [31:0]        el;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic [7:0]         q;
	} entry_t;

endpackage
`default_nettype wire

@@ design/ofsga_front.sv @@
`default_nettype none
module ofsga_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire ofsga_pkg::cfg_t    cfg,
	input  wire logic               req_type,
	input  wire logic [31:0]        time_us,
	input  wire logic               read_ok,
	input  wire logic signed [15:0] delta_x,
	input  wire logic signed [15:0] delta_y,
	input  wire logic [7:0]         quality,
	input  wire logic [7:0]         motion_status,
	input  wire logic signed [31:0] gyro_x,
	input  wire logic signed [31:0] gyro_y,
	output ofsga_pkg::entry_t       entry
);

	logic [31:0] last_time_q;
	logic [31:0] el;
	logic [16:0] adx;
	logic [16:0] ady;
	logic [16:0] lim;
	logic        delta_bad;

	// Elapsed time and absolute deltas.
	assign el  = time_us - last_time_q;
	assign adx = delta_x[15] ? 17'(~{1'b1, delta_x} + 17'd1) : {1'b0, delta_x};
	assign ady = delta_y[15] ? 17'(~{1'b1, delta_y} + 17'd1) : {1'b0, delta_y};
	assign lim = {2'b00, cfg.delta_limit};
	assign delta_bad = (cfg.delta_limit != 15'd0) && (adx >= lim || ady >= lim);

	// Classify the request; the first failing gate sets the status.
	always_comb begin
		entry        = '0;
		entry.el     = el;
		entry.dx     = delta_x;
		entry.dy     = delta_y;
		entry.gx     = gyro_x;
		entry.gy     = gyro_y;
		entry.q      = quality;
		entry.kind   = ofsga_pkg::KIND_REJECT;
		entry.status = ofsga_pkg::ST_ACCEPTED;
		if (req_type) begin
			entry.kind = ofsga_pkg::KIND_PUBLISH;
		end else if (last_time_q == 32'd0) begin
			entry.status = ofsga_pkg::ST_FIRST;
		end else if (el == 32'd0 || el > cfg.gap_limit_us) begin
			entry.status = ofsga_pkg::ST_GAP;
		end else if (!read_ok) begin
			entry.status = ofsga_pkg::ST_READFAIL;
		end else if (delta_bad) begin
			entry.status = ofsga_pkg::ST_DELTA;
		end else if (quality < cfg.quality_floor) begin
			entry.status = ofsga_pkg::ST_QUALITY;
		end else if (motion_status != ofsga_pkg::MotionValid) begin
			entry.status = ofsga_pkg::ST_MOTION;
		end else begin
			entry.kind = ofsga_pkg::KIND_SAMPLE;
		end
	end

	// Every sample moves the stored timestamp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
		end else if (take && !req_type) begin
			last_time_q <= time_us;
		end
	end

endmodule
`default_nettype wire

@@ design/ofsga_queue.sv @@
`default_nettype none
module ofsga_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ofsga_pkg::entry_t din,
	input  wire logic              pop,
	output ofsga_pkg::entry_t      head,
	output logic                   full,
	output logic                   empty
);

	localparam int PtrW = $clog2(ofsga_pkg::QueueDepth);

	ofsga_pkg::entry_t slots_q [ofsga_pkg::QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [PtrW:0]     count_q;

	assign head  = slots_q[rd_ptr_q];
	assign full  = count_q == (PtrW+1)'(ofsga_pkg::QueueDepth);
	assign empty = count_q == '0;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

@@ design/ofsga_back.sv @@
`default_nettype none
module ofsga_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ofsga_pkg::cfg_t   cfg,
	input  wire logic              q_empty,
	input  wire ofsga_pkg::entry_t q_head,
	output logic                   q_pop,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic [3:0]             status,
	output logic signed [31:0]     flow_rate_x,
	output logic signed [31:0]     flow_rate_y,
	output logic signed [31:0]     body_rate_x,
	output logic signed [31:0]     body_rate_y,
	output logic [7:0]             quality_avg
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_GX    = 11'b00000000010,
		S_GY    = 11'b00000000100,
		S_GACC  = 11'b00000001000,
		S_PM    = 11'b00000010000,
		S_PLO   = 11'b00000100000,
		S_PHI   = 11'b00001000000,
		S_LOAD  = 11'b00010000000,
		S_DIV   = 11'b00100000000,
		S_STORE = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	typedef enum logic [2:0] {
		JOB_FX = 3'd0,
		JOB_FY = 3'd1,
		JOB_BX = 3'd2,
		JOB_BY = 3'd3,
		JOB_QA = 3'd4
	} job_t;

	state_t state_q;
	job_t   job_q;

	ofsga_pkg::entry_t cur_q;

	// Window sums.
	logic signed [31:0] flow_sum_x_q;
	logic signed [31:0] flow_sum_y_q;
	logic signed [63:0] integ_x_q;
	logic signed [63:0] integ_y_q;
	logic [31:0]        window_q;
	logic [31:0]        qual_total_q;
	logic [31:0]        samples_q;

	// Shared multiplier and divider datapath.
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] prod;
	logic signed [65:0] prod_q;
	logic [62:0]        m_q;
	logic [51:0]        lo_q;
	logic [ofsga_pkg::NumW-1:0] num_q;
	logic [ofsga_pkg::DivW-1:0] div_q;
	logic [ofsga_pkg::DivW-1:0] rem_q;
	logic [31:0]                quo_q;
	logic                       ovf_q;
	logic                       neg_q;
	logic [ofsga_pkg::CntW-1:0] cnt_q;
	logic [ofsga_pkg::DivW-1:0] rem_try;
	logic                       rem_ge;

	// Results held until the publish completes.
	logic signed [31:0] res_fx_q;
	logic signed [31:0] res_fy_q;
	logic signed [31:0] res_bx_q;
	logic signed [31:0] res_by_q;

	// Output register.
	logic               out_valid_q;
	logic [3:0]         status_q;
	logic signed [31:0] fx_q;
	logic signed [31:0] fy_q;
	logic signed [31:0] bx_q;
	logic signed [31:0] by_q;
	logic [7:0]         qa_q;

	logic               ready_pub;
	logic signed [31:0] cur_sum;
	logic signed [31:0] cur_gain;
	logic [31:0]        sum_mag;
	logic [31:0]        gain_mag;
	logic signed [63:0] cur_integ;
	logic [63:0]        integ_mag;
	logic [31:0]        quo_lim;
	logic [31:0]        quo_sat;
	logic signed [31:0] rate;
	logic [7:0]         qa_val;
	logic signed [32:0] fsx;
	logic signed [32:0] fsy;
	logic signed [64:0] igx;
	logic signed [64:0] igy;
	logic [32:0]        wsum;
	logic [32:0]        qsum;
	logic [32:0]        ssum;

	assign q_pop      = (state_q == S_IDLE) && !q_empty && !out_valid_q;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign flow_rate_x = fx_q;
	assign flow_rate_y = fy_q;
	assign body_rate_x = bx_q;
	assign body_rate_y = by_q;
	assign quality_avg = qa_q;

	assign ready_pub = !(window_q < cfg.min_window_us || samples_q == 32'd0 || window_q == 32'd0);

	// Operands of the current divide job.
	assign cur_sum   = (job_q == JOB_FX) ? flow_sum_x_q : flow_sum_y_q;
	assign cur_gain  = (job_q == JOB_FX) ? cfg.gain_x : cfg.gain_y;
	assign sum_mag   = cur_sum[31] ? 32'(0 - cur_sum) : cur_sum;
	assign gain_mag  = cur_gain[31] ? 32'(0 - cur_gain) : cur_gain;
	assign cur_integ = (job_q == JOB_BX) ? integ_x_q : integ_y_q;
	assign integ_mag = cur_integ[63] ? 64'(0 - cur_integ) : cur_integ;

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_GX: begin
				mul_a = {cur_q.gx[31], cur_q.gx};
				mul_b = {1'b0, cur_q.el};
			end
			S_GY: begin
				mul_a = {cur_q.gy[31], cur_q.gy};
				mul_b = {1'b0, cur_q.el};
			end
			S_PM: begin
				mul_a = {1'b0, sum_mag};
				mul_b = {1'b0, gain_mag};
			end
			S_PLO: begin
				mul_a = {1'b0, m_q[31:0]};
				mul_b = {13'd0, ofsga_pkg::UsecPerSec};
			end
			S_PHI: begin
				mul_a = {2'd0, m_q[62:32]};
				mul_b = {13'd0, ofsga_pkg::UsecPerSec};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// One restoring divide step.
	assign rem_try = {rem_q[ofsga_pkg::DivW-2:0], num_q[ofsga_pkg::NumW-1]};
	assign rem_ge  = rem_try >= div_q;

	// Quotient saturation and sign.
	assign quo_lim = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign quo_sat = (ovf_q || quo_q > quo_lim) ? quo_lim : quo_q;
	assign rate    = neg_q ? 32'(0 - quo_sat) : quo_sat;
	assign qa_val  = (ovf_q || quo_q > 32'd255) ? 8'd255 : quo_q[7:0];

	// Saturating sums of an accepted sample.
	assign fsx  = {flow_sum_x_q[31], flow_sum_x_q} + 33'(cur_q.dx);
	assign fsy  = {flow_sum_y_q[31], flow_sum_y_q} + 33'(cur_q.dy);
	assign igx  = {integ_x_q[63], integ_x_q} + {prod_q[63], prod_q[63:0]};
	assign igy  = {integ_y_q[63], integ_y_q} + {prod_q[63], prod_q[63:0]};
	assign wsum = {1'b0, window_q} + {1'b0, cur_q.el};
	assign qsum = {1'b0, qual_total_q} + {25'd0, cur_q.q};
	assign ssum = {1'b0, samples_q} + 33'd1;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			job_q        <= JOB_FX;
			out_valid_q  <= 1'b0;
			flow_sum_x_q <= '0;
			flow_sum_y_q <= '0;
			integ_x_q    <= '0;
			integ_y_q    <= '0;
			window_q     <= '0;
			qual_total_q <= '0;
			samples_q    <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (q_head.kind == ofsga_pkg::KIND_SAMPLE) begin
							state_q <= S_GX;
						end else if (q_head.kind == ofsga_pkg::KIND_PUBLISH && ready_pub) begin
							job_q   <= JOB_FX;
							state_q <= S_PM;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_GX: begin
					flow_sum_x_q <= (fsx[32] != fsx[31]) ?
						(fsx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : fsx[31:0];
					flow_sum_y_q <= (fsy[32] != fsy[31]) ?
						(fsy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : fsy[31:0];
					window_q     <= wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
					qual_total_q <= qsum[32] ? 32'hFFFF_FFFF : qsum[31:0];
					samples_q    <= ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
					state_q      <= S_GY;
				end
				S_GY: begin
					integ_x_q <= (igx[64] != igx[63]) ?
						(igx[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : igx[63:0];
					state_q   <= S_GACC;
				end
				S_GACC: begin
					integ_y_q <= (igy[64] != igy[63]) ?
						(igy[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : igy[63:0];
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_PM: begin
					state_q <= S_PLO;
				end
				S_PLO: begin
					state_q <= S_PHI;
				end
				S_PHI: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ofsga_pkg::DivLast) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					case (job_q)
						JOB_FX: begin
							job_q   <= JOB_FY;
							state_q <= S_PM;
						end
						JOB_FY: begin
							job_q   <= JOB_BX;
							state_q <= S_LOAD;
						end
						JOB_BX: begin
							job_q   <= JOB_BY;
							state_q <= S_LOAD;
						end
						JOB_BY: begin
							job_q   <= JOB_QA;
							state_q <= S_LOAD;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_DONE: begin
					flow_sum_x_q <= '0;
					flow_sum_y_q <= '0;
					integ_x_q    <= '0;
					integ_y_q    <= '0;
					window_q     <= '0;
					qual_total_q <= '0;
					samples_q    <= '0;
					out_valid_q  <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (state_q == S_GX || state_q == S_GY) begin
			prod_q <= prod;
		end
		if (state_q == S_PM) begin
			m_q   <= prod[62:0];
			neg_q <= !(cur_sum[31] ^ cur_gain[31]);
		end
		if (state_q == S_PLO) begin
			lo_q <= prod[51:0];
		end
		if (state_q == S_PHI) begin
			num_q <= {1'b0, prod[50:0], 32'd0} + {32'd0, lo_q};
			div_q <= {1'b0, window_q, 8'd0};
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end
		if (state_q == S_LOAD) begin
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			if (job_q == JOB_QA) begin
				num_q <= {52'd0, qual_total_q};
				div_q <= {9'd0, samples_q};
				neg_q <= 1'b0;
			end else begin
				num_q <= {20'd0, integ_mag};
				div_q <= {9'd0, window_q};
				neg_q <= cur_integ[63];
			end
		end
		if (state_q == S_DIV) begin
			num_q <= {num_q[ofsga_pkg::NumW-2:0], 1'b0};
			rem_q <= rem_ge ? rem_try - div_q : rem_try;
			quo_q <= {quo_q[30:0], rem_ge};
			ovf_q <= ovf_q | quo_q[31];
		end
		if (state_q == S_STORE) begin
			case (job_q)
				JOB_FX:  res_fx_q <= rate;
				JOB_FY:  res_fy_q <= rate;
				JOB_BX:  res_bx_q <= rate;
				JOB_BY:  res_by_q <= rate;
				default: qa_q     <= qa_val;
			endcase
		end
		// Result payload.
		if (state_q == S_IDLE && q_pop) begin
			status_q <= (q_head.kind == ofsga_pkg::KIND_PUBLISH) ?
				ofsga_pkg::ST_NOT_READY : q_head.status;
			fx_q <= '0;
			fy_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			qa_q <= '0;
		end
		if (state_q == S_GACC) begin
			status_q <= ofsga_pkg::ST_ACCEPTED;
		end
		if (state_q == S_DONE) begin
			status_q <= ofsga_pkg::ST_PUBLISHED;
			fx_q <= res_fx_q;
			fy_q <= res_fy_q;
			bx_q <= res_bx_q;
			by_q <= res_by_q;
		end
	end

endmodule
`default_nettype wire

@@ design/optical_flow_sample_gate_accumulator.sv @@
`default_nettype none
// Optical flow sample gate and window accumulator. Each request is a sensor
// sample (req_type 0) or a publish (req_type 1) and gives exactly one result.
// The front end classifies a request in the cycle it is accepted and places
// it in a two-entry queue, so requests keep being taken while a result waits and the queue has room.
// The back end finishes a rejected sample or an unready publish straight from
// idle, an accepted sample via the GX, GY and GACC states (two passes through
// one shared multiplier for the gyro integrals), and a successful publish with
// five 84-step bit-serial divides (two flow rates, two body rates, mean quality)
// through one shared restoring divider, plus multiply and load steps.
// Users write configuration through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module optical_flow_sample_gate_accumulator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               req_type,
	input  wire logic [31:0]        time_us,
	input  wire logic               read_ok,
	input  wire logic signed [15:0] delta_x,
	input  wire logic signed [15:0] delta_y,
	input  wire logic [7:0]         quality,
	input  wire logic [7:0]         motion_status,
	input  wire logic signed [31:0] gyro_x,
	input  wire logic signed [31:0] gyro_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [3:0]              status,
	output logic signed [31:0]      flow_rate_x,
	output logic signed [31:0]      flow_rate_y,
	output logic signed [31:0]      body_rate_x,
	output logic signed [31:0]      body_rate_y,
	output logic [7:0]              quality_avg
);

	ofsga_pkg::cfg_t   cfg_q;
	ofsga_pkg::entry_t entry;
	ofsga_pkg::entry_t q_head;
	logic              take;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;

	assign in_stall = q_full;
	assign take     = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delta_limit   <= '0;
			cfg_q.quality_floor <= '0;
			cfg_q.gap_limit_us  <= 32'd500000;
			cfg_q.min_window_us <= 32'd100000;
			cfg_q.gain_x        <= 32'sd16777216;
			cfg_q.gain_y        <= 32'sd16777216;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ofsga_pkg::CFG_DELTA_LIMIT:   cfg_q.delta_limit   <= cfg_data[14:0];
				ofsga_pkg::CFG_QUALITY_FLOOR: cfg_q.quality_floor <= cfg_data[7:0];
				ofsga_pkg::CFG_GAP_LIMIT:     cfg_q.gap_limit_us  <= cfg_data;
				ofsga_pkg::CFG_MIN_WINDOW:    cfg_q.min_window_us <= cfg_data;
				ofsga_pkg::CFG_GAIN_X:        cfg_q.gain_x        <= cfg_data;
				ofsga_pkg::CFG_GAIN_Y:        cfg_q.gain_y        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ofsga_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.cfg           (cfg_q),
		.req_type      (req_type),
		.time_us       (time_us),
		.read_ok       (read_ok),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.quality       (quality),
		.motion_status (motion_status),
		.gyro_x        (gyro_x),
		.gyro_y        (gyro_y),
		.entry         (entry)
	);

	ofsga_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.din    (entry),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	ofsga_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.flow_rate_x (flow_rate_x),
		.flow_rate_y (flow_rate_y),
		.body_rate_x (body_rate_x),
		.body_rate_y (body_rate_y),
		.quality_avg (quality_avg)
	);

`ifndef SYNTHESIS
	// Only a publish carries nonzero rate fields.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ofsga_pkg::ST_PUBLISHED |->
		flow_rate_x == 0 && flow_rate_y == 0 && body_rate_x == 0 &&
		body_rate_y == 0 && quality_avg == 0)
		else $error("rate fields nonzero on a non-publish result");

	// The back end never takes a request while a result is still held.
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !out_valid && !q_empty)
		else $error("queue popped with output occupied or queue empty");

	// A result that is stalled is still there in the next cycle.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result lost");
`endif

endmodule
`default_nettype wire

@@ verif/ofsga_checker.sv @@
`default_nettype none
// Watches both channels and the register port, keeps its own model of the
// gate and window sums, and compares every result with the oldest one predicted.
module ofsga_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic               req_type,
	input  wire logic [31:0]        time_us,
	input  wire logic               read_ok,
	input  wire logic signed [15:0] delta_x,
	input  wire logic signed [15:0] delta_y,
	input  wire logic [7:0]         quality,
	input  wire logic [7:0]         motion_status,
	input  wire logic signed [31:0] gyro_x,
	input  wire logic signed [31:0] gyro_y,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [3:0]         status,
	input  wire logic signed [31:0] flow_rate_x,
	input  wire logic signed [31:0] flow_rate_y,
	input  wire logic signed [31:0] body_rate_x,
	input  wire logic signed [31:0] body_rate_y,
	input  wire logic [7:0]         quality_avg,
	output int                      fail_count,
	output int                      pending_count,
	output int                      windows_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		ofsga_pkg::status_t st;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [7:0]         qa;
	} flow_result_t;

	// Register copy.
	ofsga_pkg::cfg_t cfg;

	// Window state.
	logic [31:0]        prev_time;
	logic signed [31:0] sum_x, sum_y;
	logic signed [63:0] integ_x, integ_y;
	logic [31:0]        win_total, qual_total, n_samples;

	flow_result_t result_q[$];
	int n_fail;

	assign fail_count = n_fail;

	function automatic logic signed [31:0] clamp_add32(logic signed [31:0] a,
			logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647)
			return 32'h7FFFFFFF;
		if (s < -64'sd2147483648)
			return 32'h80000000;
		return s[31:0];
	endfunction

	function automatic logic signed [63:0] clamp_add64(logic signed [63:0] a,
			logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic [31:0] clamp_addu32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = a + b;
		return s[32] ? 32'hFFFFFFFF : s[31:0];
	endfunction

	// Truncating divide of a magnitude, signed and clamped to int32.
	function automatic logic signed [31:0] signed_quotient(logic [127:0] num,
			logic [127:0] den, logic neg);
		logic [127:0] q, lim;
		q = num / den;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > lim)
			q = lim;
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic logic [63:0] magnitude(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// Flow rate: minus sum times gain times one million over window times 256.
	function automatic logic signed [31:0] flow_rate_of(logic signed [31:0] sum,
			logic signed [31:0] gain, logic [31:0] win);
		logic [63:0]  m;
		logic [127:0] num;
		logic         neg;
		m = magnitude(64'(sum)) * magnitude(64'(gain));
		num = 128'(m) * 128'd1000000;
		neg = (m != 0) && ((sum < 0) == (gain < 0));
		return signed_quotient(num, {88'b0, win, 8'b0}, neg);
	endfunction

	function automatic flow_result_t predict_result();
		flow_result_t r;
		logic [31:0]        el;
		logic [15:0]        ax, ay;
		logic signed [63:0] px, py;
		r = '{ofsga_pkg::ST_ACCEPTED, 0, 0, 0, 0, 0};
		if (req_type) begin
			if (win_total < cfg.min_window_us || n_samples == 0 || win_total == 0) begin
				r.st = ofsga_pkg::ST_NOT_READY;
			end else begin
				r.st = ofsga_pkg::ST_PUBLISHED;
				r.fx = flow_rate_of(sum_x, cfg.gain_x, win_total);
				r.fy = flow_rate_of(sum_y, cfg.gain_y, win_total);
				r.bx = signed_quotient(128'(magnitude(integ_x)), 128'(win_total),
					integ_x < 0);
				r.by = signed_quotient(128'(magnitude(integ_y)), 128'(win_total),
					integ_y < 0);
				r.qa = (qual_total / n_samples > 255) ? 8'd255 : 8'(qual_total / n_samples);
				sum_x = 0;
				sum_y = 0;
				integ_x = 0;
				integ_y = 0;
				win_total = 0;
				qual_total = 0;
				n_samples = 0;
			end
		end else if (prev_time == 0) begin
			prev_time = time_us;
			r.st = ofsga_pkg::ST_FIRST;
		end else begin
			el = time_us - prev_time;
			prev_time = time_us;
			ax = delta_x < 0 ? -delta_x : delta_x;
			ay = delta_y < 0 ? -delta_y : delta_y;
			// Gates in order; the first one that fails names the status.
			if (el == 0 || el > cfg.gap_limit_us)
				r.st = ofsga_pkg::ST_GAP;
			else if (!read_ok)
				r.st = ofsga_pkg::ST_READFAIL;
			else if (cfg.delta_limit != 0 && (ax >= cfg.delta_limit || ay >= cfg.delta_limit))
				r.st = ofsga_pkg::ST_DELTA;
			else if (quality < cfg.quality_floor)
				r.st = ofsga_pkg::ST_QUALITY;
			else if (motion_status != ofsga_pkg::MotionValid)
				r.st = ofsga_pkg::ST_MOTION;
			else begin
				px = longint'(gyro_x) * longint'(el);
				py = longint'(gyro_y) * longint'(el);
				sum_x = clamp_add32(sum_x, 32'(delta_x));
				sum_y = clamp_add32(sum_y, 32'(delta_y));
				integ_x = clamp_add64(integ_x, px);
				integ_y = clamp_add64(integ_y, py);
				win_total = clamp_addu32(win_total, el);
				qual_total = clamp_addu32(qual_total, {24'b0, quality});
				n_samples = clamp_addu32(n_samples, 32'd1);
			end
		end
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
		n_fail++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		flow_result_t w;
		if (!arst_n) begin
			cfg <= '{15'd0, 8'd0, 32'd500000, 32'd100000, 32'sd16777216, 32'sd16777216};
			prev_time = 0;
			sum_x = 0;
			sum_y = 0;
			integ_x = 0;
			integ_y = 0;
			win_total = 0;
			qual_total = 0;
			n_samples = 0;
			n_fail = 0;
			windows_seen <= 0;
			pending_count <= 0;
		end else begin
			// Register writes.
			if (cfg_we) begin
				case (ofsga_pkg::cfg_idx_t'(cfg_index))
					ofsga_pkg::CFG_DELTA_LIMIT:   cfg.delta_limit <= cfg_data[14:0];
					ofsga_pkg::CFG_QUALITY_FLOOR: cfg.quality_floor <= cfg_data[7:0];
					ofsga_pkg::CFG_GAP_LIMIT:     cfg.gap_limit_us <= cfg_data;
					ofsga_pkg::CFG_MIN_WINDOW:    cfg.min_window_us <= cfg_data;
					ofsga_pkg::CFG_GAIN_X:        cfg.gain_x <= cfg_data;
					ofsga_pkg::CFG_GAIN_Y:        cfg.gain_y <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				result_q.push_back(predict_result());
			// Compare the result against the oldest prediction.
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					report("unexpected result, status", 32'(status), 32'hX);
				end else begin
					w = result_q.pop_front();
					if (status != w.st)
						report("status", 32'(status), 32'(w.st));
					if (flow_rate_x != w.fx)
						report("flow_rate_x", flow_rate_x, w.fx);
					if (flow_rate_y != w.fy)
						report("flow_rate_y", flow_rate_y, w.fy);
					if (body_rate_x != w.bx)
						report("body_rate_x", body_rate_x, w.bx);
					if (body_rate_y != w.by)
						report("body_rate_y", body_rate_y, w.by);
					if (quality_avg != w.qa)
						report("quality_avg", 32'(quality_avg), 32'(w.qa));
					if (w.st == ofsga_pkg::ST_PUBLISHED)
						windows_seen <= windows_seen + 1;
				end
			end
			pending_count <= result_q.size();
		end
	end

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 8000;

	typedef struct {
		logic               pub;
		logic [31:0]        t;
		logic               ok;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [7:0]         q;
		logic [7:0]         ms;
		logic signed [31:0] gx;
		logic signed [31:0] gy;
	} flow_req_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               req_type;
	logic [31:0]        time_us;
	logic               read_ok;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic [7:0]         quality;
	logic [7:0]         motion_status;
	logic signed [31:0] gyro_x;
	logic signed [31:0] gyro_y;
	logic               out_valid;
	logic               out_stall;
	logic [3:0]         status;
	logic signed [31:0] flow_rate_x;
	logic signed [31:0] flow_rate_y;
	logic signed [31:0] body_rate_x;
	logic signed [31:0] body_rate_y;
	logic [7:0]         quality_avg;

	int fail_count, pending_count, windows_seen;
	int n_sent;
	int idle_cycles;
	logic [31:0] now_us;
	bit calm_in, calm_out, hold_req;

	optical_flow_sample_gate_accumulator dut (.*);

	ofsga_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Output side: random stalls, quiet stretches, and one long hold-off.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (700) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (calm_out || $urandom_range(99) < 70) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(0, 3);
			end
		end
	end

	// Ends the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout with %0d results outstanding", pending_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(ofsga_pkg::cfg_idx_t idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Waits until every request has its result, then leaves the port quiet.
	task automatic drain();
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_regs(logic [31:0] dlim, logic [31:0] qfloor, logic [31:0] gap,
			logic [31:0] minwin, logic [31:0] gx, logic [31:0] gy);
		drain();
		write_reg(ofsga_pkg::CFG_DELTA_LIMIT, dlim);
		write_reg(ofsga_pkg::CFG_QUALITY_FLOOR, qfloor);
		write_reg(ofsga_pkg::CFG_GAP_LIMIT, gap);
		write_reg(ofsga_pkg::CFG_MIN_WINDOW, minwin);
		write_reg(ofsga_pkg::CFG_GAIN_X, gx);
		write_reg(ofsga_pkg::CFG_GAIN_Y, gy);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one request after an optional gap and holds it until taken.
	task automatic send(flow_req_t r);
		int gap;
		int pick;
		pick = $urandom_range(99);
		gap = (calm_in || pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3)
			: $urandom_range(10, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.pub;
		time_us <= r.t;
		read_ok <= r.ok;
		delta_x <= r.dx;
		delta_y <= r.dy;
		quality <= r.q;
		motion_status <= r.ms;
		gyro_x <= r.gx;
		gyro_y <= r.gy;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	function automatic flow_req_t noise_req();
		flow_req_t r;
		r.pub = ($urandom_range(3) == 0);
		r.t = $urandom();
		r.ok = 1'($urandom_range(1));
		r.dx = 16'($urandom());
		r.dy = 16'($urandom());
		r.q = 8'($urandom());
		r.ms = ($urandom_range(1) == 0) ? ofsga_pkg::MotionValid : 8'($urandom());
		r.gx = $urandom();
		r.gy = $urandom();
		return r;
	endfunction

	// A sample that should pass every gate under the current registers.
	function automatic flow_req_t good_sample(logic [31:0] el_max, int dmax, int qmin);
		flow_req_t r;
		now_us = now_us + $urandom_range(1, el_max);
		r = noise_req();
		r.pub = 1'b0;
		r.t = now_us;
		r.ok = 1'b1;
		r.dx = 16'($urandom_range(0, 2 * dmax) - dmax);
		r.dy = 16'($urandom_range(0, 2 * dmax) - dmax);
		r.q = 8'($urandom_range(qmin, 255));
		r.ms = ofsga_pkg::MotionValid;
		return r;
	endfunction

	function automatic flow_req_t publish_req();
		flow_req_t r;
		r = noise_req();
		r.pub = 1'b1;
		return r;
	endfunction

	task automatic run_phase(int n, logic [31:0] el_max, int dmax, int qmin);
		int pick;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) begin
				calm_in = ($urandom_range(3) == 0);
				calm_out = ($urandom_range(3) == 0);
			end
			pick = $urandom_range(99);
			if (pick < 10)
				send(publish_req());
			else if (pick < 82)
				send(good_sample(el_max, dmax, qmin));
			else
				send(noise_req());
		end
	endtask

	initial begin
		flow_req_t r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = 1'b0;
		time_us = '0;
		read_ok = 1'b0;
		delta_x = '0;
		delta_y = '0;
		quality = '0;
		motion_status = '0;
		gyro_x = '0;
		gyro_y = '0;
		n_sent = 0;
		idle_cycles = 0;
		now_us = '0;
		calm_in = 1'b0;
		calm_out = 1'b0;
		hold_req = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every gate and status, field extremes, timestamp wrap.
		set_regs(1000, 10, 500000, 1000, 32'sd16777216, 32'sd16777216);
		r = good_sample(1, 0, 10);
		r.t = 32'd0;
		send(r);                           // a zero time keeps the block unstarted
		r.t = 32'd1000;
		send(r);                           // start
		send(publish_req());               // no samples yet
		send(r);                           // zero elapsed time
		r.t = 32'd601000;
		send(r);                           // gap too long
		r.t = 32'd602000;
		r.ok = 1'b0;
		send(r);                           // read failure
		r.t = 32'd603000;
		r.ok = 1'b1;
		r.dx = 16'sh8000;
		send(r);                           // delta too large
		r.t = 32'd604000;
		r.dx = 16'sd999;
		r.dy = -16'sd999;
		r.q = 8'd0;
		send(r);                           // quality below the floor
		r.t = 32'd605000;
		r.q = 8'd255;
		r.ms = 8'h00;
		send(r);                           // bad motion status
		r.t = 32'd606000;
		r.ms = ofsga_pkg::MotionValid;
		r.gx = 32'sh80000000;
		r.gy = 32'sh7FFFFFFF;
		send(r);                           // accepted, extreme gyro
		r.t = 32'd906000;
		r.dx = -16'sd999;
		r.dy = 16'sd999;
		r.gx = 32'sh7FFFFFFF;
		r.gy = 32'sh80000000;
		r.q = 8'd10;
		send(r);
		send(publish_req());               // ready
		send(publish_req());               // window cleared
		r.t = 32'hFFFFFF00;
		send(r);                           // gap across the wrap
		r.t = 32'h00000100;
		send(r);                           // elapsed time wraps
		now_us = r.t;

		// Mild limits; the output holds off while requests keep coming.
		set_regs(100, 50, 30000, 20000, $urandom(), $urandom());
		hold_req = 1'b1;
		run_phase(400, 8000, 99, 50);

		// Extremes of every register, with huge elapsed times.
		set_regs(32767, 255, 32'hFFFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF);
		run_phase(300, 32'hFFFFFFFF, 32767, 255);

		// Tight gap and delta gates; a publish is ready only with a saturated window.
		set_regs(1, 0, 1, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF);
		run_phase(50, 1, 0, 0);

		// Delta and quality gates disabled, random gains.
		set_regs(0, 0, 500000, 100000, $urandom(), $urandom());
		run_phase(400, 40000, 32767, 0);

		drain();
		repeat (100) @(posedge clk);
		$display("Sent %0d requests over five register settings; %0d windows published.",
			n_sent, windows_seen);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
